### rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must hold its value into the next cycle when the condition is true
`define ASSERT_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

### rtl/dsdp_pkg.sv
// Package for the dual step/direction pulse generator.
// Holds the default speed width and the per-channel output struct.
package dsdp_pkg;

    // Default width of a signed speed target
    localparam int SPEED_WIDTH_DEF = 16;

    // Result of one tick for one channel
    typedef struct packed {
        logic step;
        logic dir;
    } chan_out_t;

endpackage

### rtl/dsdp_channel.sv
// One step/direction channel: run state, tick counter, period threshold.
// Depends on dsdp_pkg for the output struct.
module dsdp_channel #(
    parameter int   SPEED_WIDTH = dsdp_pkg::SPEED_WIDTH_DEF,
    parameter logic INVERT      = 1'b0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic signed [SPEED_WIDTH-1:0] speed,
    output dsdp_pkg::chan_out_t           result
);

    localparam logic [SPEED_WIDTH-1:0] ONE = {{(SPEED_WIDTH-1){1'b0}}, 1'b1};

    logic                   halted_reg, halted_next;
    logic [SPEED_WIDTH-1:0] cnt_reg, cnt_next;
    logic [SPEED_WIDTH-1:0] thr_reg, thr_next;
    logic                   dir_reg, dir_next;

    logic                   neg;
    logic                   nonzero;
    logic [SPEED_WIDTH-1:0] raw;
    logic [SPEED_WIDTH-1:0] mag;
    logic                   dir_target;
    logic [SPEED_WIDTH-1:0] cnt_inc;

    // Decode the target: magnitude, sign and direction level
    always_comb
    begin
        raw        = speed;
        neg        = raw[SPEED_WIDTH-1];
        nonzero    = |raw;
        mag        = neg ? (~raw + ONE) : raw;
        dir_target = ~neg ^ INVERT;
        cnt_inc    = cnt_reg + ONE;
    end

    // Start, count, wrap, reload or stop
    always_comb
    begin
        halted_next = halted_reg;
        cnt_next    = cnt_reg;
        thr_next    = thr_reg;
        dir_next    = dir_reg;
        if (halted_reg)
        begin
            if (nonzero)
            begin
                halted_next = 1'b0;
                cnt_next    = '0;
                thr_next    = mag;
                dir_next    = dir_target;
            end
        end
        else
        begin
            cnt_next = cnt_inc;
            if (cnt_inc > thr_reg)
            begin
                cnt_next = '0;
                if (!nonzero)
                begin
                    halted_next = 1'b1;
                end
                else
                begin
                    thr_next = mag;
                    dir_next = dir_target;
                end
            end
        end
    end

    // Drive this tick's step and direction
    always_comb
    begin
        result.step = !halted_next && (cnt_next == ONE);
        result.dir  = dir_next;
    end

    // Advance channel state once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg <= 1'b1;
            cnt_reg    <= '0;
            thr_reg    <= '0;
            dir_reg    <= 1'b0;
        end
        else if (advance)
        begin
            halted_reg <= halted_next;
            cnt_reg    <= cnt_next;
            thr_reg    <= thr_next;
            dir_reg    <= dir_next;
        end
    end

endmodule

### rtl/dual_step_dir_pulse_generator_unit.sv
// Path: out_valid rises when the result reg takes the accepted item (input reg, then result reg).
// Throughput: one item per cycle unless stalled; the channel counter update is the only logic per stage.
// A stalled result holds while one more item waits in the input register.
// Reset (rst_n low, asynchronous): both channels stopped, counters, thresholds and
// direction levels zero, both pipeline stages empty.
module dual_step_dir_pulse_generator_unit #(
    parameter int SPEED_WIDTH = dsdp_pkg::SPEED_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SPEED_WIDTH-1:0] speed_left,
    input  logic signed [SPEED_WIDTH-1:0] speed_right,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          step_left,
    output logic                          dir_left,
    output logic                          step_right,
    output logic                          dir_right
);

    logic                          in_valid_reg;
    logic signed [SPEED_WIDTH-1:0] speed_left_reg;
    logic signed [SPEED_WIDTH-1:0] speed_right_reg;
    logic                          out_valid_reg;
    dsdp_pkg::chan_out_t           left_reg;
    dsdp_pkg::chan_out_t           right_reg;

    logic                          out_free;
    logic                          advance;
    dsdp_pkg::chan_out_t           left_res;
    dsdp_pkg::chan_out_t           right_res;

    // Handshake: the result stage frees when empty or taken
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    // Capture the incoming item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            speed_left_reg  <= speed_left;
            speed_right_reg <= speed_right;
        end
    end

    dsdp_channel #(
        .SPEED_WIDTH (SPEED_WIDTH),
        .INVERT      (1'b0)
    ) u_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .speed   (speed_left_reg),
        .result  (left_res)
    );

    dsdp_channel #(
        .SPEED_WIDTH (SPEED_WIDTH),
        .INVERT      (1'b1)
    ) u_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .speed   (speed_right_reg),
        .result  (right_res)
    );

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_reg  <= left_res;
            right_reg <= right_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign step_left  = left_reg.step;
    assign dir_left   = left_reg.dir;
    assign step_right = right_reg.step;
    assign dir_right  = right_reg.dir;

endmodule

### rtl/dsdp_checker.sv
// Port-level checker for the dual step/direction pulse generator, bound to the top level.
// Depends on assert_macros.svh for the assertion macros.
`include "assert_macros.svh"

module dsdp_checker #(
    parameter int SPEED_WIDTH = dsdp_pkg::SPEED_WIDTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic signed [SPEED_WIDTH-1:0] speed_left,
    input logic signed [SPEED_WIDTH-1:0] speed_right,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          step_left,
    input logic                          dir_left,
    input logic                          step_right,
    input logic                          dir_right
);

    logic last_step_l_reg;
    logic last_step_r_reg;
    logic out_take;
    logic [3:0] out_bits;
    logic [2*SPEED_WIDTH:0] in_bits;

    assign out_take = out_valid && out_ready;
    assign out_bits = {step_left, dir_left, step_right, dir_right};
    assign in_bits  = {in_valid, speed_left, speed_right};

    // Remember the step bits of the last delivered item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_step_l_reg <= 1'b0;
            last_step_r_reg <= 1'b0;
        end
        else if (out_take)
        begin
            last_step_l_reg <= step_left;
            last_step_r_reg <= step_right;
        end
    end

    // A waiting input item stays offered and unchanged
    `ASSERT_HOLD(a_in_stable, in_valid && !in_ready, in_bits, "input changed while waiting")

    // A stalled result stays offered and unchanged
    `ASSERT_CLK(a_out_valid_holds, out_valid && !out_ready |=> out_valid, "result dropped")
    `ASSERT_HOLD(a_out_stable, out_valid && !out_ready, out_bits, "result changed")

    // A period is at least two ticks, so steps never come on back-to-back items
    `ASSERT_CLK(a_left_no_double, out_take && step_left |-> !last_step_l_reg, "left double step")
    `ASSERT_CLK(a_right_no_double, out_take && step_right |-> !last_step_r_reg, "right double step")

endmodule

bind dual_step_dir_pulse_generator_unit dsdp_checker #(.SPEED_WIDTH(SPEED_WIDTH)) u_dsdp_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the dual step/direction pulse generator.
// Drives speed targets over a valid/ready channel and checks every result
// against a cycle-free channel predictor or a typed-in row result; depends on dsdp_pkg and the unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW          = dsdp_pkg::SPEED_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_TICKS = 6;
    localparam int RAND_ITEMS  = 185;
    localparam int LONG_HOLD   = 16;

    typedef logic signed [SW-1:0] speed_t;

    // Per-channel state: counter and threshold one bit wider than a target
    typedef struct packed {
        logic        halted;
        logic [SW:0] cnt;
        logic [SW:0] thr;
        logic        dir;
    } chan_state_t;

    // One tick of results, left channel in the upper bits
    typedef struct packed {
        dsdp_pkg::chan_out_t left;
        dsdp_pkg::chan_out_t right;
    } tick_res_t;

    // Directed row: targets, and a typed-in result where one is given
    typedef struct packed {
        speed_t    tgt_l;
        speed_t    tgt_r;
        logic      fixed;
        tick_res_t res;
    } speed_row_t;

    // Result bits are {step_left, dir_left, step_right, dir_right}
    localparam speed_row_t SPEED_ROWS [19] = '{
        '{ 16'sd0,      16'sd0,     1'b1, 4'b0000 },  // stopped after reset
        '{ 16'sd1,     -16'sd1,     1'b1, 4'b0101 },  // start tick, no step yet
        '{ 16'sd1,     -16'sd1,     1'b0, 4'b0000 },
        '{ 16'sd1,     -16'sd1,     1'b0, 4'b0000 },
        '{ 16'sd1,     -16'sd1,     1'b0, 4'b0000 },
        '{-16'sd1,      16'sd1,     1'b0, 4'b0000 },  // flip direction at wrap
        '{-16'sd1,      16'sd1,     1'b0, 4'b0000 },
        '{ 16'sd0,      16'sd0,     1'b0, 4'b0000 },  // stop, dir holds
        '{ 16'sd0,      16'sd0,     1'b0, 4'b0000 },
        '{ 16'sd2,      16'sd3,     1'b0, 4'b0000 },
        '{-16'sd5,     -16'sd7,     1'b0, 4'b0000 },  // ignored mid-period
        '{ 16'sd0,      16'sd0,     1'b0, 4'b0000 },
        '{ 16'sd0,      16'sd0,     1'b0, 4'b0000 },
        '{ 16'sd4,      16'sd0,     1'b0, 4'b0000 },
        '{ 16'sd4,     -16'sd4,     1'b0, 4'b0000 },
        '{ 16'sd4,     -16'sd4,     1'b0, 4'b0000 },
        '{ 16'sd0,      16'sd0,     1'b0, 4'b0000 },
        '{-16'sd6,      16'sd6,     1'b0, 4'b0000 },
        '{ 16'sd0,      16'sd0,     1'b0, 4'b0000 }
    };

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    speed_t speed_left = '0;
    speed_t speed_right = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    logic   step_left;
    logic   dir_left;
    logic   step_right;
    logic   dir_right;

    // Typed-in result travelling with the item on the input side
    logic      cur_fixed = 1'b0;
    tick_res_t cur_fixed_res = '0;

    chan_state_t left_st  = '{halted: 1'b1, cnt: '0, thr: '0, dir: 1'b0};
    chan_state_t right_st = '{halted: 1'b1, cnt: '0, thr: '0, dir: 1'b0};
    tick_res_t   pending_res_q [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_count = 0;
    int cycle_count = 0;

    string res_name [4] = '{"dir_right", "step_right", "dir_left", "step_left"};

    dual_step_dir_pulse_generator_unit #(.SPEED_WIDTH(SW)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .speed_left (speed_left),
        .speed_right(speed_right),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .step_left  (step_left),
        .dir_left   (dir_left),
        .step_right (step_right),
        .dir_right  (dir_right)
    );

    always #5 clk = ~clk;

    // Advance one channel by one tick; inv flips the direction wiring
    task automatic tick_channel(inout chan_state_t cs, input speed_t tgt,
                                input logic inv, output logic stp);
        logic [SW:0] ext;
        logic [SW:0] mag;
        logic        nz;
        logic        dnew;
        ext  = {tgt[SW-1], tgt};
        mag  = tgt[SW-1] ? -ext : ext;
        nz   = |tgt;
        dnew = ~tgt[SW-1] ^ inv;
        stp  = 1'b0;
        if (cs.halted) begin
            if (nz) begin
                cs.halted = 1'b0;
                cs.cnt    = '0;
                cs.thr    = mag;
                cs.dir    = dnew;
            end
        end
        else begin
            cs.cnt = cs.cnt + 1'b1;
            if (cs.cnt > cs.thr) begin
                cs.cnt = '0;
                if (!nz) begin
                    cs.halted = 1'b1;
                end
                else begin
                    cs.thr = mag;
                    cs.dir = dnew;
                end
            end
            stp = !cs.halted && (cs.cnt == 1);
        end
    endtask

    // Pick a target: mostly short periods with either sign, some stops
    function automatic speed_t pick_speed();
        int     roll;
        int     mag;
        speed_t v;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            mag = 0;
        else if (roll < 70)
            mag = $urandom_range(1, 6);
        else if (roll < 88)
            mag = $urandom_range(7, 40);
        else
            mag = $urandom_range(41, 300);
        v = mag[SW-1:0];
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    // Present one item at the falling edge and hold it until accepted
    task automatic send_speed(input speed_t tl, input speed_t tr,
                              input logic fx, input tick_res_t fres);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        speed_left    = tl;
        speed_right   = tr;
        cur_fixed     = fx;
        cur_fixed_res = fres;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Drop or raise ready on the result side at the falling edge
    always @(negedge clk) begin
        out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check the oldest expected result, then predict for the accepted item
    always @(posedge clk) begin
        tick_res_t act;
        tick_res_t exp_res;
        tick_res_t pred;
        logic      sl;
        logic      sr;
        if (rst_n && out_valid && out_ready) begin
            act = {step_left, dir_left, step_right, dir_right};
            if (pending_res_q.size() == 0) begin
                $display("%0t: result %b arrived with none expected", $time, act);
                err_count++;
            end
            else begin
                exp_res = pending_res_q.pop_front();
                for (int i = 3; i >= 0; i--) begin
                    if (act[i] !== exp_res[i]) begin
                        $display("%0t: %s expected %b got %b", $time, res_name[i],
                                 exp_res[i], act[i]);
                        err_count++;
                    end
                end
            end
        end
        if (rst_n && in_valid && in_ready) begin
            tick_channel(left_st, speed_left, 1'b0, sl);
            tick_channel(right_st, speed_right, 1'b1, sr);
            pred.left.step  = sl;
            pred.left.dir   = left_st.dir;
            pred.right.step = sr;
            pred.right.dir  = right_st.dir;
            pending_res_q.push_back(cur_fixed ? cur_fixed_res : pred);
        end
    end

    // Abort a run that stops making progress
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dual_step_dir_pulse_generator_unit test failed");
            $finish;
        end
    end

    initial begin
        speed_t tgt_l;
        speed_t tgt_r;
        speed_t drv_l;
        speed_t drv_r;
        int     hold_l;
        int     hold_r;
        tgt_l  = '0;
        tgt_r  = '0;
        hold_l = 0;
        hold_r = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            // Sender idles lightly while receiver stalls hard, then swap, then none
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 68 : 0;
            recv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 15 : 0;

            if (ph == 0) begin
                foreach (SPEED_ROWS[i])
                    send_speed(SPEED_ROWS[i].tgt_l, SPEED_ROWS[i].tgt_r,
                               SPEED_ROWS[i].fixed, SPEED_ROWS[i].res);
            end

            // Hold each target for a run of ticks; inject noise mid-period
            for (int n = 0; n < RAND_ITEMS; n++) begin
                if (hold_l == 0) begin
                    tgt_l  = pick_speed();
                    hold_l = $urandom_range(1, 12);
                end
                if (hold_r == 0) begin
                    tgt_r  = pick_speed();
                    hold_r = $urandom_range(1, 12);
                end
                hold_l--;
                hold_r--;
                drv_l = tgt_l;
                drv_r = tgt_r;
                if (!left_st.halted && left_st.cnt < left_st.thr
                    && $urandom_range(0, 3) == 0)
                    drv_l = speed_t'($urandom);
                if (!right_st.halted && right_st.cnt < right_st.thr
                    && $urandom_range(0, 3) == 0)
                    drv_r = speed_t'($urandom);
                send_speed(drv_l, drv_r, 1'b0, '0);
            end
        end

        // Extremes: stop both, then start at the most negative and most positive targets
        while (!left_st.halted || !right_st.halted)
            send_speed('0, '0, 1'b0, '0);
        repeat (LONG_HOLD)
            send_speed({1'b1, {(SW-1){1'b0}}}, {1'b0, {(SW-1){1'b1}}}, 1'b0, '0);
        in_valid = 1'b0;

        while (pending_res_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);

        if (err_count == 0)
            $display("dual_step_dir_pulse_generator_unit test passed");
        else
            $display("dual_step_dir_pulse_generator_unit test failed");
        $finish;
    end

endmodule
